// File: design/rht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rht_pkg;

  // Command codes carried in the cmd field.
  typedef enum logic [3:0] {
    CMD_ALLOC     = 4'd0,
    CMD_ADDREF    = 4'd1,
    CMD_SUBREF    = 4'd2,
    CMD_CHECK     = 4'd3,
    CMD_ADDR2HND  = 4'd4,
    CMD_HND2ADDR  = 4'd5,
    CMD_REMOVE    = 4'd6,
    CMD_SWEEP     = 4'd7,
    CMD_SWEEP_DUE = 4'd8,
    CMD_CLEAR     = 4'd9
  } rht_cmd_t;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROT_ADDR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_INT = 4'd1;

  localparam logic [15:0] SWEEP_INT_RESET = 16'd1024;
  localparam logic signed [15:0] RC_MAX = 16'sd32767;
  localparam logic signed [15:0] RC_MIN = -16'sd32768;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [10:0] obj_handle;
    logic [31:0] obj_address;
    logic [3:0]  obj_kind;
    logic        dispose_ok;
  } rht_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] value;
    logic [31:0]        address_out;
    logic [3:0]         kind_out;
  } rht_out_t;

endpackage
`default_nettype wire

// File: design/rht_entry_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Entry table storage: one write port, one read port, registered read data.
module rht_entry_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 53
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/rht_free_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Queue of freed handles, handed back in the order they were freed.
module rht_free_fifo #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11,
  parameter int unsigned CW    = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr,
  input  wire logic          push,
  input  wire logic [AW-1:0] push_data,
  input  wire logic          pop,
  output logic      [AW-1:0] pop_data,
  output logic      [CW-1:0] count
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          do_push;

  // Tail position wraps at the queue depth.
  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (tail_sum >= (CW+1)'(DEPTH)) begin
      tail = AW'(tail_sum - (CW+1)'(DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
    do_push = push && (count_r != CW'(DEPTH));
  end

  // Pointer and fill count updates.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (clr) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (pop) begin
        head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      end
      if (do_push && !pop) begin
        count_nxt = count_r + CW'(1);
      end else if (pop && !do_push) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push && !clr) begin
      mem[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pop_data <= mem[head_r];
    end
  end

  assign count = count_r;

endmodule
`default_nettype wire

// File: design/refcounted_handle_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                               Transfer when
// input     start, busy, in_data                start high and busy low
// result    out_valid, out_data                 out_valid high (one cycle, no stall)
// config    cfg_valid, cfg_ready, cfg_index,    cfg_valid and cfg_ready high
//           cfg_data
//
// Alloc from a fresh handle, pool full, invalid handles, sweeps not yet due, unknown
// commands and null addresses finish in the accept cycle; alloc from the free queue and
// handle commands first read the queue or entry RAM, then write back. Searches, sweeps and
// clear-all walk the used handle range one entry per cycle. The result is registered and
// appears in the cycle after the work ends. Reset is synchronous; entry contents need
// no clearing, as only handles below the fresh-handle mark are read.
module refcounted_handle_table_core #(
  parameter int unsigned TABLE_SIZE   = 2048,
  parameter int unsigned ADDRESS_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire rht_pkg::rht_in_t                in_data,
  output logic                                 out_valid,
  output rht_pkg::rht_out_t                    out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  import rht_pkg::*;

  localparam int unsigned HW = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(TABLE_SIZE + 1);
  localparam int unsigned EW = ADDRESS_BITS + 21;
  localparam int unsigned KL = ADDRESS_BITS;
  localparam int unsigned RL = ADDRESS_BITS + 4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_RMW  = 4'b0100,
    S_WALK = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  rht_in_t           req_r, req_nxt;
  logic [CW-1:0]     fresh_r, fresh_nxt;
  logic [15:0]       ccount_r, ccount_nxt;
  logic [31:0]       prot_r;
  logic [15:0]       intv_r;
  logic [CW-1:0]     walk_r, walk_nxt;
  logic [HW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              any_r, any_nxt;
  logic [HW-1:0]     hnd_r, hnd_nxt;
  logic              out_valid_r, out_valid_nxt;
  rht_out_t          out_r, out_nxt;

  logic              ram_we, ram_re;
  logic [HW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  logic              fq_clr, fq_push, fq_pop;
  logic [HW-1:0]     fq_push_data, fq_pop_data;
  logic [CW-1:0]     fq_count;

  logic                    accept;
  logic [16:0]             h_ext;
  logic                    h_ok;
  logic [ADDRESS_BITS-1:0] addr_in, req_addr, prot_addr, d_addr;
  logic [3:0]              d_kind;
  logic signed [15:0]      d_rc, new_rc;
  logic                    d_used;

  rht_entry_ram #(.DEPTH(TABLE_SIZE), .AW(HW), .DW(EW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rht_free_fifo #(.DEPTH(TABLE_SIZE), .AW(HW), .CW(CW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (fq_clr),
    .push      (fq_push),
    .push_data (fq_push_data),
    .pop       (fq_pop),
    .pop_data  (fq_pop_data),
    .count     (fq_count)
  );

  // Field views of the request and of the entry read back.
  always_comb begin
    accept    = start && (state_r == S_IDLE);
    h_ext     = 17'(in_data.obj_handle);
    h_ok      = (h_ext != 17'd0) && (h_ext < 17'(fresh_r));
    addr_in   = ADDRESS_BITS'(in_data.obj_address);
    req_addr  = ADDRESS_BITS'(req_r.obj_address);
    prot_addr = ADDRESS_BITS'(prot_r);
    d_addr    = ram_rdata[ADDRESS_BITS-1:0];
    d_kind    = ram_rdata[KL+3:KL];
    d_rc      = $signed(ram_rdata[RL+15:RL]);
    d_used    = ram_rdata[EW-1];
  end

  // Sequencer: command decode, read-modify-write and table walks.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    fresh_nxt     = fresh_r;
    ccount_nxt    = ccount_r;
    walk_nxt      = walk_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = rd_vld_r;
    any_nxt       = any_r;
    hnd_nxt       = hnd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = rd_idx_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = walk_r[HW-1:0];
    fq_clr        = 1'b0;
    fq_push       = 1'b0;
    fq_push_data  = rd_idx_r;
    fq_pop        = 1'b0;
    new_rc        = d_rc;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          out_nxt = '0;
          case (in_data.cmd)
            CMD_ALLOC: begin
              if (fq_count != '0) begin
                fq_pop    = 1'b1;
                state_nxt = S_POP;
              end else if (fresh_r < CW'(TABLE_SIZE)) begin
                ram_we        = 1'b1;
                ram_waddr     = fresh_r[HW-1:0];
                ram_wdata     = {1'b1, 16'd0, in_data.obj_kind, addr_in};
                fresh_nxt     = fresh_r + CW'(1);
                ccount_nxt    = (ccount_r != 16'hFFFF) ? ccount_r + 16'd1 : ccount_r;
                out_nxt.value = 16'(fresh_r);
                out_valid_nxt = 1'b1;
              end else begin
                out_nxt.status = ST_FULL;
                out_valid_nxt  = 1'b1;
              end
            end
            CMD_ADDREF, CMD_SUBREF, CMD_CHECK, CMD_HND2ADDR: begin
              if (h_ok) begin
                ram_re    = 1'b1;
                ram_raddr = HW'(in_data.obj_handle);
                hnd_nxt   = HW'(in_data.obj_handle);
                state_nxt = S_RMW;
              end else begin
                out_nxt.status = ST_INVALID;
                out_nxt.value  = (in_data.cmd == CMD_CHECK) ? 16'sd1 : 16'sd0;
                out_valid_nxt  = 1'b1;
              end
            end
            CMD_ADDR2HND, CMD_REMOVE: begin
              if (addr_in == '0) begin
                out_nxt.status = ST_INVALID;
                out_valid_nxt  = 1'b1;
              end else begin
                walk_nxt   = CW'(1);
                rd_vld_nxt = 1'b0;
                any_nxt    = 1'b0;
                state_nxt  = S_WALK;
              end
            end
            CMD_SWEEP, CMD_CLEAR: begin
              walk_nxt   = CW'(1);
              rd_vld_nxt = 1'b0;
              any_nxt    = 1'b0;
              state_nxt  = S_WALK;
            end
            CMD_SWEEP_DUE: begin
              if (ccount_r > intv_r) begin
                ccount_nxt = '0;
                walk_nxt   = CW'(1);
                rd_vld_nxt = 1'b0;
                any_nxt    = 1'b0;
                state_nxt  = S_WALK;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_nxt.status = ST_INVALID;
              out_valid_nxt  = 1'b1;
            end
          endcase
        end
      end

      // Handle from the free queue is now available.
      S_POP: begin
        ram_we        = 1'b1;
        ram_waddr     = fq_pop_data;
        ram_wdata     = {1'b1, 16'd0, req_r.obj_kind, req_addr};
        ccount_nxt    = (ccount_r != 16'hFFFF) ? ccount_r + 16'd1 : ccount_r;
        out_nxt.value = 16'(fq_pop_data);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // Entry of the named handle has been read; update and write back.
      S_RMW: begin
        ram_waddr     = hnd_r;
        fq_push_data  = hnd_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (!d_used) begin
          out_nxt.status = ST_INVALID;
          out_nxt.value  = (req_r.cmd == CMD_CHECK) ? 16'sd1 : 16'sd0;
        end else begin
          case (req_r.cmd)
            CMD_ADDREF: begin
              new_rc        = (d_rc == RC_MAX) ? d_rc : d_rc + 16'sd1;
              ram_we        = 1'b1;
              ram_wdata     = {1'b1, new_rc, d_kind, d_addr};
              out_nxt.value = new_rc;
            end
            CMD_SUBREF: begin
              new_rc        = (d_rc == RC_MIN) ? d_rc : d_rc - 16'sd1;
              ram_we        = 1'b1;
              out_nxt.value = new_rc;
              if ((d_addr != prot_addr) && (new_rc <= 16'sd0) && req_r.dispose_ok) begin
                ram_wdata = '0;
                fq_push   = 1'b1;
              end else begin
                ram_wdata = {1'b1, new_rc, d_kind, d_addr};
              end
            end
            CMD_CHECK: begin
              if ((d_rc < 16'sd1) && req_r.dispose_ok) begin
                ram_we        = 1'b1;
                ram_wdata     = '0;
                fq_push       = 1'b1;
                out_nxt.value = 16'sd1;
              end
            end
            CMD_HND2ADDR: begin
              out_nxt.address_out = 32'(d_addr);
              out_nxt.kind_out    = d_kind;
            end
            default: begin
              out_nxt.status = ST_INVALID;
            end
          endcase
        end
      end

      // Walk handles 1 up to one below the fresh mark, one read issued per cycle.
      S_WALK: begin
        if (walk_r < fresh_r) begin
          ram_re     = 1'b1;
          ram_raddr  = walk_r[HW-1:0];
          walk_nxt   = walk_r + CW'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = walk_r[HW-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end

        if (rd_vld_r) begin
          case (req_r.cmd)
            CMD_ADDR2HND, CMD_REMOVE: begin
              if (d_used && (d_addr == req_addr)) begin
                if (req_r.cmd == CMD_REMOVE) begin
                  ram_we        = 1'b1;
                  fq_push       = 1'b1;
                  out_nxt.value = 16'sd1;
                end else begin
                  out_nxt.value = 16'(rd_idx_r);
                end
                out_valid_nxt = 1'b1;
                rd_vld_nxt    = 1'b0;
                state_nxt     = S_IDLE;
              end
            end
            CMD_SWEEP, CMD_SWEEP_DUE: begin
              if (d_used && (d_rc < 16'sd1) && req_r.dispose_ok) begin
                ram_we  = 1'b1;
                fq_push = 1'b1;
                any_nxt = 1'b1;
              end
            end
            CMD_CLEAR: begin
              if (d_used) begin
                ram_we  = 1'b1;
                any_nxt = 1'b1;
              end
            end
            default: begin
              rd_vld_nxt = 1'b0;
            end
          endcase
        end else if (walk_r >= fresh_r) begin
          // Walk complete with nothing left in flight.
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          case (req_r.cmd)
            CMD_ADDR2HND, CMD_REMOVE: begin
              out_nxt.status = ST_INVALID;
            end
            CMD_CLEAR: begin
              out_nxt.value = 16'(any_r);
              fq_clr        = 1'b1;
              fresh_nxt     = CW'(1);
            end
            default: begin
              out_nxt.value = 16'(any_r);
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fresh_r     <= CW'(1);
      ccount_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      prot_r      <= '0;
      intv_r      <= SWEEP_INT_RESET;
    end else begin
      state_r     <= state_nxt;
      fresh_r     <= fresh_nxt;
      ccount_r    <= ccount_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PROT_ADDR) begin
          prot_r <= cfg_data;
        end else if (cfg_index == CFG_SWEEP_INT) begin
          intv_r <= cfg_data[15:0];
        end
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    walk_r   <= walk_nxt;
    rd_idx_r <= rd_idx_nxt;
    any_r    <= any_nxt;
    hnd_r    <= hnd_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: design/rht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the handle table.
module rht_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire rht_pkg::rht_out_t out_data
);

  import rht_pkg::*;

  // A result follows either an accepted command or a busy period.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) || $past(busy)))
    else $error("result without a preceding command");

  // Status codes stay within the defined set.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_INVALID ||
                   out_data.status == ST_FULL))
    else $error("undefined status code");

  // A full pool reports no handle.
  a_full_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.value == 16'sd0))
    else $error("pool full with non-zero value");

  // A failed lookup returns no address or type.
  a_err_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.address_out == 32'd0 && out_data.kind_out == 4'd0))
    else $error("address returned with error status");

endmodule

bind refcounted_handle_table_core rht_checker u_rht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rht_pkg::*;

  localparam int unsigned SLOTS = 2048;
  localparam int unsigned WALK_CYCLES = SLOTS + 8;

  // Scoreboard: a copy of the handle table state and the queue of predicted responses.
  class handle_table_sb;
    bit          used [SLOTS];
    shortint     refs [SLOTS];
    logic [31:0] addr [SLOTS];
    logic [3:0]  kind [SLOTS];
    int          recycled [$];
    int          fresh_mark;
    int          creations;
    logic [31:0] prot_addr;
    logic [15:0] interval;
    rht_out_t    awaited [$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        used[i] = 0;
        refs[i] = 0;
        addr[i] = '0;
        kind[i] = '0;
      end
      fresh_mark = 1;
      creations = 0;
      prot_addr = '0;
      interval = SWEEP_INT_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_PROT_ADDR) prot_addr = data;
      else if (idx == CFG_SWEEP_INT) interval = data[15:0];
    endfunction

    function bit live(int h);
      return h >= 1 && h < SLOTS && used[h];
    endfunction

    // Releases an entry; unforced releases need the owner's consent.
    function bit release_entry(int h, bit forced, bit ok);
      if (!forced && !ok) return 0;
      recycled.push_back(h);
      used[h] = 0;
      refs[h] = 0;
      addr[h] = '0;
      kind[h] = '0;
      return 1;
    endfunction

    function int lookup(logic [31:0] a);
      if (a == '0) return 0;
      for (int i = 1; i < SLOTS; i++)
        if (used[i] && addr[i] == a) return i;
      return 0;
    endfunction

    function bit collect(bit ok);
      bit any;
      any = 0;
      for (int i = 1; i < fresh_mark && i < SLOTS; i++)
        if (used[i] && refs[i] < 1) any |= release_entry(i, 0, ok);
      return any;
    endfunction

    // Works out the response to one accepted command and queues it.
    function void note_command(rht_in_t c);
      rht_out_t r;
      int h;
      int n;
      r = '0;
      h = c.obj_handle;
      case (c.cmd)
        CMD_ALLOC: begin
          n = 0;
          if (recycled.size() > 0) n = recycled.pop_front();
          else if (fresh_mark < SLOTS) begin
            n = fresh_mark;
            fresh_mark++;
          end
          if (n == 0) r.status = ST_FULL;
          else begin
            used[n] = 1;
            refs[n] = 0;
            addr[n] = c.obj_address;
            kind[n] = c.obj_kind;
            if (creations < 65535) creations++;
            r.value = 16'(n);
          end
        end
        CMD_ADDREF: begin
          if (!live(h)) r.status = ST_INVALID;
          else begin
            if (refs[h] < 32767) refs[h]++;
            r.value = refs[h];
          end
        end
        CMD_SUBREF: begin
          if (!live(h)) r.status = ST_INVALID;
          else begin
            if (refs[h] > -32768) refs[h]--;
            r.value = refs[h];
            if (addr[h] != prot_addr && refs[h] <= 0)
              void'(release_entry(h, 0, c.dispose_ok));
          end
        end
        CMD_CHECK: begin
          if (!live(h)) begin
            r.status = ST_INVALID;
            r.value = 16'sd1;
          end else if (refs[h] < 1) begin
            r.value = 16'(release_entry(h, 0, c.dispose_ok));
          end
        end
        CMD_ADDR2HND: begin
          n = lookup(c.obj_address);
          if (n == 0) r.status = ST_INVALID;
          else r.value = 16'(n);
        end
        CMD_HND2ADDR: begin
          if (!live(h)) r.status = ST_INVALID;
          else begin
            r.address_out = addr[h];
            r.kind_out = kind[h];
          end
        end
        CMD_REMOVE: begin
          n = lookup(c.obj_address);
          if (n == 0) r.status = ST_INVALID;
          else r.value = 16'(release_entry(n, 1, c.dispose_ok));
        end
        CMD_SWEEP: r.value = 16'(collect(c.dispose_ok));
        CMD_SWEEP_DUE: begin
          if (creations > interval) begin
            r.value = 16'(collect(c.dispose_ok));
            creations = 0;
          end
        end
        CMD_CLEAR: begin
          for (int i = 1; i < fresh_mark && i < SLOTS; i++)
            if (used[i]) r.value[0] = r.value[0] | release_entry(i, 1, c.dispose_ok);
          recycled.delete();
          fresh_mark = 1;
        end
        default: r.status = ST_INVALID;
      endcase
      awaited.push_back(r);
    endfunction

    // Compares one response with the oldest prediction.
    function void check_response(rht_out_t got);
      rht_out_t exp;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected response %p", got);
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status || got.value !== exp.value ||
          got.address_out !== exp.address_out || got.kind_out !== exp.kind_out) begin
        errors++;
        if (errors <= 10)
          $display("Response mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  rht_in_t              in_data;
  logic                 out_valid;
  rht_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  handle_table_sb sb;
  logic [31:0]    addr_pool [8];

  refcounted_handle_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Every response strobe is a transfer and is checked at once.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_response(out_data);
  end

  function automatic rht_in_t mk(rht_cmd_t c, int h, logic [31:0] a, int k, bit ok);
    rht_in_t it;
    it.cmd = c;
    it.obj_handle = 11'(h);
    it.obj_address = a;
    it.obj_kind = 4'(k);
    it.dispose_ok = ok;
    return it;
  endfunction

  // Holds start high until the command transfers; start is left high.
  task automatic send(rht_in_t it);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.note_command(it);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers back to back while the table is idle.
  task automatic write_regs(logic [31:0] prot, logic [15:0] ival);
    drain();
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_PROT_ADDR : CFG_SWEEP_INT;
      cfg_data <= (i == 0) ? prot : {16'd0, ival};
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg((i == 0) ? CFG_PROT_ADDR : CFG_SWEEP_INT, (i == 0) ? prot : {16'd0, ival});
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_live();
    int live [$];
    for (int i = 1; i < SLOTS; i++)
      if (sb.used[i]) live.push_back(i);
    if (live.size() == 0) return $urandom_range(0, SLOTS - 1);
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Mostly well-formed commands on live handles and known addresses, some noise.
  function automatic rht_in_t random_command();
    rht_in_t it;
    int w;
    int h;
    w = $urandom_range(0, 99);
    if (w < 25) it.cmd = CMD_ALLOC;
    else if (w < 45) it.cmd = CMD_ADDREF;
    else if (w < 65) it.cmd = CMD_SUBREF;
    else if (w < 72) it.cmd = CMD_CHECK;
    else if (w < 79) it.cmd = CMD_ADDR2HND;
    else if (w < 86) it.cmd = CMD_HND2ADDR;
    else if (w < 91) it.cmd = CMD_REMOVE;
    else if (w < 93) it.cmd = CMD_SWEEP;
    else if (w < 96) it.cmd = CMD_SWEEP_DUE;
    else if (w < 97) it.cmd = CMD_CLEAR;
    else it.cmd = 4'($urandom_range(10, 15));
    it.obj_handle = ($urandom_range(0, 3) != 0) ? 11'(pick_live())
                                               : 11'($urandom_range(0, SLOTS - 1));
    w = $urandom_range(0, 9);
    if (w < 5) it.obj_address = addr_pool[$urandom_range(0, 7)];
    else if (w < 8) begin
      h = pick_live();
      it.obj_address = sb.live(h) ? sb.addr[h] : addr_pool[$urandom_range(0, 7)];
    end else it.obj_address = $urandom;
    it.obj_kind = 4'($urandom_range(0, 15));
    it.dispose_ok = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  // A phase of random commands sent in bursts with gaps of random length.
  task automatic random_phase(int count);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
      end
      send(random_command());
      burst--;
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sb = new();
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) addr_pool[i] = $urandom | 32'h1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: duplicates, null addresses, consent, invalid handles and commands.
    send(mk(CMD_ALLOC, 0, 32'hFFFF_FFFF, 15, 1));
    send(mk(CMD_ALLOC, 0, addr_pool[2], 0, 1));
    send(mk(CMD_ALLOC, 0, addr_pool[2], 5, 1));
    send(mk(CMD_ALLOC, 0, 32'h0, 9, 1));
    send(mk(CMD_ADDREF, 1, 0, 0, 1));
    send(mk(CMD_SUBREF, 1, 0, 0, 0));
    send(mk(CMD_CHECK, 1, 0, 0, 0));
    send(mk(CMD_CHECK, 0, 0, 0, 1));
    send(mk(CMD_CHECK, SLOTS - 1, 0, 0, 1));
    send(mk(CMD_ADDR2HND, 0, addr_pool[2], 0, 1));
    send(mk(CMD_ADDR2HND, 0, 32'h0, 0, 1));
    send(mk(CMD_HND2ADDR, 1, 0, 0, 1));
    send(mk(CMD_HND2ADDR, 5, 0, 0, 1));
    send(mk(CMD_REMOVE, 0, 32'h1234_5678, 0, 1));
    send(mk(CMD_REMOVE, 0, 32'h0, 0, 1));
    send(mk(CMD_REMOVE, 0, addr_pool[2], 0, 0));
    send(mk(CMD_SWEEP, 0, 0, 0, 0));
    send(mk(CMD_SWEEP_DUE, 0, 0, 0, 1));
    send(mk(CMD_SWEEP, 0, 0, 0, 1));
    send(mk(CMD_ALLOC, 0, addr_pool[3], 3, 1));
    send(mk(CMD_ADDREF, 2047, 0, 0, 1));
    send(mk(rht_cmd_t'(4'd15), 0, 0, 0, 1));
    send(mk(CMD_CLEAR, 0, 0, 0, 1));
    drain();

    // Allocate a batch, then sweep the lot when due and reuse a freed handle.
    write_regs(32'h0, 16'd0);
    for (int i = 0; i < 10; i++)
      send(mk(CMD_ALLOC, 0, $urandom, $urandom_range(0, 15), 1));
    send(mk(CMD_HND2ADDR, 10, 0, 0, 1));
    send(mk(CMD_SWEEP_DUE, 0, 0, 0, 1));
    send(mk(CMD_ALLOC, 0, addr_pool[4], 1, 1));
    send(mk(CMD_CLEAR, 0, 0, 0, 0));
    drain();

    // Drive the count of a protected entry negative; it then falls to a sweep.
    write_regs(addr_pool[5], 16'd0);
    send(mk(CMD_ALLOC, 0, addr_pool[5], 7, 1));
    for (int i = 0; i < 3; i++) send(mk(CMD_ADDREF, 1, 0, 0, 1));
    for (int i = 0; i < 6; i++) send(mk(CMD_SUBREF, 1, 0, 0, 1));
    send(mk(CMD_HND2ADDR, 1, 0, 0, 1));
    send(mk(CMD_SWEEP, 0, 0, 0, 1));
    send(mk(CMD_CLEAR, 0, 0, 0, 1));
    drain();

    // Random phases under different register settings.
    write_regs(addr_pool[2], 16'd0);
    random_phase(125);
    write_regs(32'hFFFF_FFFF, 16'hFFFF);
    random_phase(125);
    write_regs(32'h0, 16'd3);
    random_phase(125);
    write_regs($urandom, 16'($urandom_range(0, 40)));
    random_phase(125);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(200_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
